/* src/accel_tilt_angles_defines.svh */
// Assertion macros for the tilt angle block.
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

`ifndef SYNTHESIS
`define ATILT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("tilt angle check failed");
`define ATILT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("tilt angle check failed");
`else
`define ATILT_ASSERT_IMP(label, ante, cons)
`define ATILT_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* src/atilt_pkg.sv */
// Shared types, constants and the arctangent table of the tilt angle block.
package atilt_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STAGES_DEF   = 16;

    localparam int RAW_W    = 16;
    localparam int CPG_W    = 13;
    localparam int DIV_BITS = 16;
    localparam int MAG_W    = 17;
    localparam int V_W      = 18;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int CORDIC_W = 34;
    localparam int ANG_W    = 16;
    localparam int PRE_SHIFT = 14;

    localparam logic [CPG_W-1:0] CPG_RESET = 13'd32;
    localparam logic [MAG_W-1:0] ONE_G     = 17'd65536;

    localparam logic [20:0] DEG_NUM   = 21'd1800000;
    localparam logic [53:0] DEG_DEN   = 54'd31415;
    localparam int          RECIP_SH  = 46;
    localparam logic [63:0] DEG_RECIP = ((64'd1 << RECIP_SH) + 64'd31414) / 64'd31415;
    localparam logic [53:0] DEG_SAT   = 54'd2058813440;

    typedef struct packed {
        logic signed [RAW_W-1:0] accel_x;
        logic signed [RAW_W-1:0] accel_y;
        logic signed [RAW_W-1:0] accel_z;
    } t_accel_in;

    typedef struct packed {
        logic [ANG_W-1:0] angle_x;
        logic [ANG_W-1:0] angle_y;
        logic [ANG_W-1:0] angle_z;
        logic             zero_vector;
    } t_angle_out;

    typedef struct packed {
        logic                          valid;
        logic [2:0]                    neg;
        logic [2:0]                    sat;
        logic [2:0][CPG_W-1:0]         rem;
        logic [2:0][DIV_BITS-1:0]      quo;
    } t_div_beat;

    typedef struct packed {
        logic                          valid;
        logic                          zero;
        logic [2:0][V_W-1:0]           v;
        logic [2:0][SUM_W-1:0]         n;
        logic [2:0][REM_W-1:0]         rem;
        logic [2:0][ROOT_W-1:0]        root;
    } t_sqrt_beat;

    typedef struct packed {
        logic                          valid;
        logic                          zero;
        logic [2:0][CORDIC_W-1:0]      x;
        logic [2:0][CORDIC_W-1:0]      y;
        logic [2:0][CORDIC_W-1:0]      z;
    } t_cordic_beat;

    // atan(2^-idx) in Q30, rounded
    function automatic logic [CORDIC_W-1:0] atilt_atan(input int idx);
        case (idx)
            0:  return 34'd843314857;
            1:  return 34'd497837829;
            2:  return 34'd263043837;
            3:  return 34'd133525159;
            4:  return 34'd67021687;
            5:  return 34'd33543516;
            6:  return 34'd16775851;
            7:  return 34'd8388437;
            8:  return 34'd4194283;
            9:  return 34'd2097149;
            10: return 34'd1048576;
            11: return 34'd524288;
            12: return 34'd262144;
            13: return 34'd131072;
            14: return 34'd65536;
            15: return 34'd32768;
            16: return 34'd16384;
            17: return 34'd8192;
            18: return 34'd4096;
            19: return 34'd2048;
            20: return 34'd1024;
            21: return 34'd512;
            22: return 34'd256;
            23: return 34'd128;
            default: return '0;
        endcase
    endfunction

endpackage

/* src/atilt_div_cell.sv */
// One quotient bit of the per-axis scaling divider, three axes side by side.
module atilt_div_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [atilt_pkg::CPG_W-1:0]   i_cpg,
    input  atilt_pkg::t_div_beat          i_beat,
    output atilt_pkg::t_div_beat          o_beat
);
    import atilt_pkg::*;

    t_div_beat r_out;
    t_div_beat n_out;

    always_comb begin
        logic [CPG_W:0] t;
        logic           ge;
        n_out = i_beat;
        for (int l = 0; l < 3; l++) begin
            t  = {i_beat.rem[l], 1'b0};
            ge = (t >= {1'b0, i_cpg});
            n_out.rem[l] = ge ? CPG_W'(t - {1'b0, i_cpg}) : t[CPG_W-1:0];
            n_out.quo[l] = {i_beat.quo[l][DIV_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_beat = r_out;

endmodule

/* src/atilt_sqrt_cell.sv */
// One root bit of the digit-by-digit square root, three lanes side by side.
module atilt_sqrt_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  atilt_pkg::t_sqrt_beat   i_beat,
    output atilt_pkg::t_sqrt_beat   o_beat
);
    import atilt_pkg::*;
`include "accel_tilt_angles_defines.svh"

    t_sqrt_beat r_out;
    t_sqrt_beat n_out;

    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;
        n_out = i_beat;
        for (int l = 0; l < 3; l++) begin
            rem_sh = {i_beat.rem[l][REM_W-3:0], i_beat.n[l][SUM_W-1 -: 2]};
            trial  = REM_W'({i_beat.root[l], 2'b01});
            ge     = (rem_sh >= trial);
            n_out.rem[l]  = ge ? (rem_sh - trial) : rem_sh;
            n_out.root[l] = {i_beat.root[l][ROOT_W-2:0], ge};
            n_out.n[l]    = {i_beat.n[l][SUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_beat = r_out;

    // partial remainder never exceeds twice the partial root
    `ATILT_ASSERT_IMP(a_rem_bound, r_out.valid, ((r_out.rem[0] <= REM_W'({r_out.root[0], 1'b0})) && (r_out.rem[1] <= REM_W'({r_out.root[1], 1'b0})) && (r_out.rem[2] <= REM_W'({r_out.root[2], 1'b0}))))

endmodule

/* src/atilt_cordic_cell.sv */
// One vectoring CORDIC iteration, three lanes side by side.
module atilt_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  atilt_pkg::t_cordic_beat   i_beat,
    output atilt_pkg::t_cordic_beat   o_beat
);
    import atilt_pkg::*;

    localparam logic [CORDIC_W-1:0] ATAN = atilt_atan(STAGE);

    t_cordic_beat r_out;
    t_cordic_beat n_out;

    always_comb begin
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        n_out = i_beat;
        for (int l = 0; l < 3; l++) begin
            xs = $signed(i_beat.x[l]);
            ys = $signed(i_beat.y[l]);
            dx = ys >>> STAGE;
            dy = xs >>> STAGE;
            if (ys >= 0) begin
                n_out.x[l] = xs + dx;
                n_out.y[l] = ys - dy;
                n_out.z[l] = i_beat.z[l] + ATAN;
            end else begin
                n_out.x[l] = xs - dx;
                n_out.y[l] = ys + dy;
                n_out.z[l] = i_beat.z[l] - ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_beat = r_out;

endmodule

/* src/atilt_deg.sv */
// Radians-to-degrees conversion with rounding and saturation, three stages.
module atilt_deg #(
    parameter int ANGLE_FRAC_BITS = atilt_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  atilt_pkg::t_cordic_beat   i_beat,
    output logic                      o_strobe,
    output atilt_pkg::t_angle_out     o_result
);
    import atilt_pkg::*;

    localparam int          SHIFT    = 30 - ANGLE_FRAC_BITS;
    localparam logic [53:0] HALF_DEN = DEG_DEN << (SHIFT - 1);

    logic              r1_valid;
    logic              r1_zero;
    logic [2:0][52:0]  r1_prod;
    logic              r2_valid;
    logic              r2_zero;
    logic [2:0]        r2_sat;
    logic [2:0][62:0]  r2_prod;
    logic              r3_valid;
    t_angle_out        r3_res;

    logic [2:0][52:0]  n1_prod;
    logic [2:0]        n2_sat;
    logic [2:0][62:0]  n2_prod;
    logic [2:0][ANG_W-1:0] n3_ang;

    always_comb begin
        logic [31:0] zc;
        logic [53:0] m;
        for (int l = 0; l < 3; l++) begin
            zc = i_beat.z[l][CORDIC_W-1] ? 32'd0 : i_beat.z[l][31:0];
            n1_prod[l] = 53'(zc) * 53'(DEG_NUM);
            m = (54'(r1_prod[l]) + HALF_DEN) >> SHIFT;
            n2_sat[l]  = (m >= DEG_SAT);
            n2_prod[l] = 63'(m[30:0]) * 63'(DEG_RECIP[31:0]);
            n3_ang[l]  = r2_zero ? '0 :
                         r2_sat[l] ? '1 : r2_prod[l][RECIP_SH +: ANG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_beat.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zero            <= i_beat.zero;
        r1_prod            <= n1_prod;
        r2_zero            <= r1_zero;
        r2_sat             <= n2_sat;
        r2_prod            <= n2_prod;
        r3_res.angle_x     <= n3_ang[0];
        r3_res.angle_y     <= n3_ang[1];
        r3_res.angle_z     <= n3_ang[2];
        r3_res.zero_vector <= r2_zero;
    end

    assign o_strobe = r3_valid;
    assign o_result = r3_res;

endmodule

/* src/accel_tilt_angles.sv */
// Top level of the accelerometer tilt angle block.
//
// Input: pulse start with a three-axis sample on i_sample; the beat is taken at
// the rising edge where start is high and busy is low. busy is low whenever
// reset is released, so a new sample can be taken in every cycle.
// Output: one result per sample on o_result, marked by o_strobe for exactly one
// cycle. The receiver cannot hold results off; every beat must be taken.
// Pipeline: one input stage, 16 divider cells (one quotient bit each), two
// square/sum stages, 17 square-root cells (one root bit each), one
// pre-rotation stage, CORDIC_STAGES CORDIC cells and three degree stages.
// Throughput: one sample per cycle.
// Configuration: i_cfg_we writes counts_per_g (reset value 32); write only
// while the pipeline is empty. A value of zero is treated as one.
// Reset: synchronous, active low; clears all valid bits, so no strobe follows
// until a new sample arrives.
module accel_tilt_angles #(
    parameter int ANGLE_FRAC_BITS = atilt_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = atilt_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  atilt_pkg::t_accel_in          i_sample,
    input  logic                          i_cfg_we,
    input  logic [atilt_pkg::CPG_W-1:0]   i_cfg_wdata,
    output logic                          o_strobe,
    output atilt_pkg::t_angle_out         o_result
);
    import atilt_pkg::*;
`include "accel_tilt_angles_defines.svh"

    localparam int LAT = 40 + CORDIC_STAGES;

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic [2:0][V_W-1:0]     v;
        logic [2:0][MAG_W-1:0]   mag;
        logic [2:0][SQ_W-1:0]    sq;
    } t_sq_beat;

    logic [CPG_W-1:0] r_counts_per_g;
    logic [CPG_W-1:0] w_cpg;

    t_div_beat    r_in;
    t_div_beat    n_in;
    t_div_beat    w_div [0:DIV_BITS];
    t_sq_beat     r_sq;
    t_sq_beat     n_sq;
    t_sqrt_beat   r_sum;
    t_sqrt_beat   n_sum;
    t_sqrt_beat   w_sqrt [0:ROOT_W];
    t_cordic_beat r_pre;
    t_cordic_beat n_pre;
    t_cordic_beat w_cor [0:CORDIC_STAGES];

    logic [2:0][RAW_W-1:0] w_raw;

    assign busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts_per_g <= CPG_RESET;
        end else if (i_cfg_we) begin
            r_counts_per_g <= i_cfg_wdata;
        end
    end

    assign w_cpg    = (r_counts_per_g == '0) ? CPG_W'(1) : r_counts_per_g;
    assign w_raw[0] = i_sample.accel_x;
    assign w_raw[1] = i_sample.accel_y;
    assign w_raw[2] = i_sample.accel_z;

    // sign, magnitude and saturation of each raw axis
    always_comb begin
        logic [RAW_W-1:0] m;
        n_in       = '0;
        n_in.valid = start && !busy;
        for (int l = 0; l < 3; l++) begin
            n_in.neg[l] = w_raw[l][RAW_W-1];
            m = w_raw[l][RAW_W-1] ? (~w_raw[l] + 1'b1) : w_raw[l];
            n_in.sat[l] = (m >= RAW_W'(w_cpg));
            n_in.rem[l] = n_in.sat[l] ? '0 : m[CPG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in <= n_in;
        end
    end

    assign w_div[0] = r_in;

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
        atilt_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cpg   (w_cpg),
            .i_beat  (w_div[g]),
            .o_beat  (w_div[g+1])
        );
    end

    always_comb begin
        logic [MAG_W-1:0] m;
        n_sq.valid = w_div[DIV_BITS].valid;
        for (int l = 0; l < 3; l++) begin
            m = w_div[DIV_BITS].sat[l] ? ONE_G : {1'b0, w_div[DIV_BITS].quo[l]};
            n_sq.mag[l] = m;
            n_sq.v[l]   = w_div[DIV_BITS].neg[l] ? (-{1'b0, m}) : {1'b0, m};
            n_sq.sq[l]  = SQ_W'(m) * SQ_W'(m);
        end
        n_sq.zero = (n_sq.mag[0] == '0) && (n_sq.mag[1] == '0) && (n_sq.mag[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.valid <= 1'b0;
        end else begin
            r_sq <= n_sq;
        end
    end

    always_comb begin
        n_sum       = '0;
        n_sum.valid = r_sq.valid;
        n_sum.zero  = r_sq.zero;
        n_sum.v     = r_sq.v;
        n_sum.n[0]  = r_sq.sq[1] + r_sq.sq[2];
        n_sum.n[1]  = r_sq.sq[2] + r_sq.sq[0];
        n_sum.n[2]  = r_sq.sq[0] + r_sq.sq[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum.valid <= 1'b0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign w_sqrt[0] = r_sum;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        atilt_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_sqrt[g]),
            .o_beat  (w_sqrt[g+1])
        );
    end

    // negative axis: rotate by 90 degrees first
    always_comb begin
        logic [CORDIC_W-1:0] xa;
        logic [CORDIC_W-1:0] yr;
        n_pre.valid = w_sqrt[ROOT_W].valid;
        n_pre.zero  = w_sqrt[ROOT_W].zero;
        for (int l = 0; l < 3; l++) begin
            xa = {{(CORDIC_W-V_W-PRE_SHIFT){w_sqrt[ROOT_W].v[l][V_W-1]}},
                  w_sqrt[ROOT_W].v[l], {PRE_SHIFT{1'b0}}};
            yr = {{(CORDIC_W-ROOT_W-PRE_SHIFT){1'b0}},
                  w_sqrt[ROOT_W].root[l], {PRE_SHIFT{1'b0}}};
            if (w_sqrt[ROOT_W].v[l][V_W-1]) begin
                n_pre.x[l] = yr;
                n_pre.y[l] = -xa;
                n_pre.z[l] = atilt_atan(0) << 1;
            end else begin
                n_pre.x[l] = xa;
                n_pre.y[l] = yr;
                n_pre.z[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else begin
            r_pre <= n_pre;
        end
    end

    assign w_cor[0] = r_pre;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        atilt_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_cor[g]),
            .o_beat  (w_cor[g+1])
        );
    end

    atilt_deg #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_deg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_cor[CORDIC_STAGES]),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    `ATILT_ASSERT_IMP(a_lat_fwd, start && !busy, ##LAT o_strobe)
    `ATILT_ASSERT_IMP(a_lat_none, !(start && !busy), ##LAT !o_strobe)
    `ATILT_ASSERT_IMP(a_mag_clamp, r_sq.valid, ((r_sq.mag[0] <= ONE_G) && (r_sq.mag[1] <= ONE_G) && (r_sq.mag[2] <= ONE_G)))

endmodule

/* test/accel_tilt_angles_tb.sv */
// Testbench for accel_tilt_angles: random and directed samples checked against a tilt predictor.
`timescale 1ns / 100ps

module accel_tilt_angles_tb;
    import atilt_pkg::*;

    typedef struct {
        bit                cfg_write;
        logic [CPG_W-1:0]  cfg_val;
        t_accel_in         sample;
        int                gap;
    } t_drive_req;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    t_accel_in    i_sample = '0;
    logic         i_cfg_we = 1'b0;
    logic [CPG_W-1:0] i_cfg_wdata = '0;
    logic         o_strobe;
    t_angle_out   o_result;

    t_drive_req   pending_q[$];
    t_angle_out   angle_exp_q[$];
    longint       atan_q30[24];
    longint       cur_cpg = 32;
    int           gap_left = 0;
    int           quiet_cycles = 0;
    int           fail_count = 0;

    accel_tilt_angles u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void build_arctan_table();
        longint unsigned sum, term;
        int e;
        atan_q30[0] = 843314857;
        for (int i = 1; i < 24; i++) begin
            sum = 0;
            for (int k = 0; k < 40; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e < 0) break;
                term = (64'd1 << e) / longint'(2 * k + 1);
                if (term == 0) break;
                if ((k & 1) == 0) sum += term;
                else sum -= term;
            end
            atan_q30[i] = longint'((sum + (64'd1 << 31)) >> 32);
        end
    endfunction

    function automatic longint scale_to_g(logic signed [RAW_W-1:0] raw, longint cpg);
        longint v;
        v = (longint'(raw) * 65536) / cpg;
        if (v > 65536) v = 65536;
        if (v < -65536) v = -65536;
        return v;
    endfunction

    function automatic longint floor_root(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic logic [ANG_W-1:0] tilt_degrees(longint a, longint r);
        longint x, y, z, t, dx, dy;
        longint unsigned num, den, deg;
        x = a * 16384;
        y = r * 16384;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 2 * atan_q30[0];
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += atan_q30[i];
            end else begin
                x -= dx;
                y += dy;
                z -= atan_q30[i];
            end
        end
        if (z < 0) z = 0;
        num = longint'(z) * 1800000;
        den = 64'd31415 << 22;
        deg = (num + den / 2) / den;
        if (deg > 65535) deg = 65535;
        return deg[ANG_W-1:0];
    endfunction

    function automatic t_angle_out predict_tilt(t_accel_in s);
        t_angle_out res;
        longint v[3];
        longint b, c;
        logic [ANG_W-1:0] ang[3];
        longint cpg;
        cpg = (cur_cpg == 0) ? 1 : cur_cpg;
        v[0] = scale_to_g(s.accel_x, cpg);
        v[1] = scale_to_g(s.accel_y, cpg);
        v[2] = scale_to_g(s.accel_z, cpg);
        res = '0;
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
            res.zero_vector = 1'b1;
            return res;
        end
        for (int j = 0; j < 3; j++) begin
            b = v[(j + 1) % 3];
            c = v[(j + 2) % 3];
            ang[j] = tilt_degrees(v[j], floor_root(longint'(b * b + c * c)));
        end
        res.angle_x = ang[0];
        res.angle_y = ang[1];
        res.angle_z = ang[2];
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit cfg_fire;
        cfg_fire = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                angle_exp_q.push_back(predict_tilt(i_sample));
            if (!start && angle_exp_q.size() == 0) quiet_cycles++;
            else quiet_cycles = 0;
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_q.size() == 0) begin
                    start <= 1'b0;
                end else if (pending_q[0].cfg_write) begin
                    start <= 1'b0;
                    if (!start && quiet_cycles > 64) begin
                        cfg_fire = 1'b1;
                        i_cfg_wdata <= pending_q[0].cfg_val;
                        cur_cpg = longint'(pending_q[0].cfg_val);
                        void'(pending_q.pop_front());
                    end
                end else begin
                    start <= 1'b1;
                    i_sample <= pending_q[0].sample;
                    gap_left = pending_q[0].gap;
                    void'(pending_q.pop_front());
                end
            end
        end
        i_cfg_we <= cfg_fire;
    end

    // monitor
    always @(posedge i_clk) begin
        t_angle_out want;
        if (i_rst_n && o_strobe) begin
            if (angle_exp_q.size() == 0) begin
                $error("result beat with nothing expected: %h", o_result);
                fail_count++;
            end else begin
                want = angle_exp_q.pop_front();
                if (o_result.angle_x !== want.angle_x) begin
                    $error("angle_x exp %0d got %0d", want.angle_x, o_result.angle_x);
                    fail_count++;
                end
                if (o_result.angle_y !== want.angle_y) begin
                    $error("angle_y exp %0d got %0d", want.angle_y, o_result.angle_y);
                    fail_count++;
                end
                if (o_result.angle_z !== want.angle_z) begin
                    $error("angle_z exp %0d got %0d", want.angle_z, o_result.angle_z);
                    fail_count++;
                end
                if (o_result.zero_vector !== want.zero_vector) begin
                    $error("zero_vector exp %0d got %0d", want.zero_vector,
                           o_result.zero_vector);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [RAW_W-1:0] rand_axis(int mode, longint cpg);
        int lim;
        case (mode)
            0: return RAW_W'($urandom);
            1: begin
                lim = (cpg > 16383) ? 32767 : int'(cpg) * 2;
                return RAW_W'($urandom_range(0, 2 * lim) - lim);
            end
            2: return RAW_W'($urandom_range(0, 6) - 3);
            default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        endcase
    endfunction

    task automatic queue_sample(input logic [RAW_W-1:0] x, y, z, input int gap);
        t_drive_req r;
        r.cfg_write = 0;
        r.cfg_val = '0;
        r.sample.accel_x = x;
        r.sample.accel_y = y;
        r.sample.accel_z = z;
        r.gap = gap;
        pending_q.push_back(r);
    endtask

    task automatic queue_cfg(input logic [CPG_W-1:0] val);
        t_drive_req r;
        r.cfg_write = 1;
        r.cfg_val = val;
        r.sample = '0;
        r.gap = 0;
        pending_q.push_back(r);
    endtask

    initial begin
        logic [CPG_W-1:0] cfg_plan[10];
        logic [CPG_W-1:0] val;
        int n_items, max_gap;
        build_arctan_table();
        cfg_plan = '{13'd32, 13'd1, 13'd4096, 13'd0, 13'd8191,
                     13'd16, 13'd1000, 13'd3, 13'd2048, 13'd500};

        queue_sample(16'd0, 16'd0, 16'd0, 0);
        queue_sample(16'h7fff, 16'h7fff, 16'h7fff, 0);
        queue_sample(16'h8000, 16'h8000, 16'h8000, 1);
        queue_sample(16'd32, 16'd0, 16'd0, 0);
        queue_sample(-16'sd32, 16'd0, 16'd0, 0);
        queue_sample(16'd0, 16'd32, 16'd0, 2);
        queue_sample(16'd0, -16'sd32, 16'd0, 0);
        queue_sample(16'd0, 16'd0, 16'd32, 0);
        queue_sample(16'd0, 16'd0, -16'sd32, 3);
        queue_sample(16'd1, 16'd0, 16'd0, 0);
        queue_sample(16'hffff, 16'hffff, 16'hffff, 0);
        queue_sample(16'd16, 16'd16, 16'd16, 0);
        queue_sample(-16'sd16, 16'd16, -16'sd16, 5);
        queue_sample(16'h8000, 16'd0, 16'h7fff, 0);
        queue_sample(16'd1, 16'd1, 16'd1, 0);
        queue_sample(-16'sd1, -16'sd1, -16'sd1, 13);
        queue_sample(16'd5, -16'sd7, 16'd11, 0);
        queue_sample(16'd0, 16'd0, 16'h8000, 0);

        for (int p = 0; p < 10; p++) begin
            val = (p < 9) ? cfg_plan[p] : CPG_W'($urandom_range(1, 4096));
            queue_cfg(val);
            if (val == 0 || val == 1) begin
                queue_sample(16'd0, 16'd0, 16'd0, 0);
                queue_sample(16'd1, 16'd0, 16'd0, 0);
            end else begin
                queue_sample(16'(val - 1), 16'd0, 16'd0, 0);
                queue_sample(16'd0, -16'(val - 1), 16'd0, 0);
            end
            n_items = 85 + $urandom_range(0, 10);
            max_gap = (p % 3 == 1) ? 0 : 13;
            for (int k = 0; k < n_items; k++) begin
                int m;
                m = $urandom_range(0, 9);
                m = (m < 4) ? 0 : (m < 8) ? 1 : (m < 9) ? 2 : 3;
                queue_sample(rand_axis(m, val), rand_axis(m, val), rand_axis(m, val),
                             $urandom_range(0, max_gap));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || angle_exp_q.size() != 0 || start)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && angle_exp_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/atilt_pkg.sv
src/atilt_div_cell.sv
src/atilt_sqrt_cell.sv
src/atilt_cordic_cell.sv
src/atilt_deg.sv
src/accel_tilt_angles.sv
test/accel_tilt_angles_tb.sv
